// ===== sv/q2e_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table for the quaternion to Euler block.
// No dependencies.
`default_nettype none
package q2e_pkg;

	localparam int QUAT_FRAC_BITS   = 14;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int QW  = 16;               // quaternion component width
	localparam int PW  = 2 * QW;           // product width
	localparam int SW  = PW + 2;           // atan2 argument width
	localparam int TW  = 32;               // pitch sine at 30 fraction bits
	localparam int CW  = 38;               // CORDIC datapath width
	localparam int AW  = 32;               // binary angle, 2^31 = pi
	localparam int OW  = 16;               // output angle width
	localparam int SQ_ITERS = 31;          // result bits of the square root
	localparam int NW  = 2 * SQ_ITERS;     // radicand width
	localparam int TSH = 30 - 2 * QUAT_FRAC_BITS;

	localparam logic [OW-1:0] PITCH_POS = 16'h4000;
	localparam logic [OW-1:0] PITCH_NEG = 16'hC000;

	typedef struct packed {
		logic signed [SW-1:0] sr;
		logic signed [SW-1:0] cr;
		logic signed [SW-1:0] sy;
		logic signed [SW-1:0] cy;
	} atan_args_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} pitch_sat_t;

	function automatic logic [AW-1:0] atan_ent(input int i);
		logic [AW-1:0] v;
		unique case (i)
			0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
			3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
			9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
			15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
			21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
			24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
			27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
			30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/q2e_front.sv =====
// Front end: component products, atan2 arguments, pitch sine and saturation flags.
// Depends on q2e_pkg.
`default_nettype none
module q2e_front
	import q2e_pkg::*;
(
	input  wire                  clk,
	input  wire                  en,
	input  wire signed [QW-1:0]  quat_x,
	input  wire signed [QW-1:0]  quat_y,
	input  wire signed [QW-1:0]  quat_z,
	input  wire signed [QW-1:0]  quat_w,
	output atan_args_t           args,     // valid at stage 2
	output logic signed [TW-1:0] t_out,    // valid at stage 3
	output pitch_sat_t           sat_out   // valid at stage 3
);

	localparam logic signed [SW-1:0] ONE = SW'(64'sd1 <<< (2 * QUAT_FRAC_BITS));

	logic signed [PW-1:0] pwx_s1, pyz_s1, pxx_s1, pyy_s1, pwz_s1, pxy_s1, pzz_s1;
	logic signed [PW-1:0] pwy_s1, pzx_s1;
	logic signed [SW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, s_s2;
	logic signed [TW-1:0] t_s3;
	logic                 pos_s3, neg_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pwx_s1 <= quat_w * quat_x;
			pyz_s1 <= quat_y * quat_z;
			pxx_s1 <= quat_x * quat_x;
			pyy_s1 <= quat_y * quat_y;
			pwz_s1 <= quat_w * quat_z;
			pxy_s1 <= quat_x * quat_y;
			pzz_s1 <= quat_z * quat_z;
			pwy_s1 <= quat_w * quat_y;
			pzx_s1 <= quat_z * quat_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= (SW'(pwx_s1) + SW'(pyz_s1)) <<< 1;
			cr_s2 <= ONE - ((SW'(pxx_s1) + SW'(pyy_s1)) <<< 1);
			sy_s2 <= (SW'(pwz_s1) + SW'(pxy_s1)) <<< 1;
			cy_s2 <= ONE - ((SW'(pyy_s1) + SW'(pzz_s1)) <<< 1);
			s_s2  <= (SW'(pwy_s1) - SW'(pzx_s1)) <<< 1;
		end
	end

	// sine brought to 30 fraction bits; only meaningful when not saturated
	always_ff @(posedge clk) begin
		if (en) begin
			t_s3   <= TW'(s_s2 <<< TSH);
			pos_s3 <= (s_s2 >= ONE);
			neg_s3 <= (s_s2 <= -ONE);
		end
	end

	assign args.sr     = sr_s2;
	assign args.cr     = cr_s2;
	assign args.sy     = sy_s2;
	assign args.cy     = cy_s2;
	assign t_out       = t_s3;
	assign sat_out.pos = pos_s3;
	assign sat_out.neg = neg_s3;

endmodule
`default_nettype wire

// ===== sv/q2e_root.sv =====
// Pitch cosine: c = floor(sqrt(2^60 - t*t)), one result bit per pipeline stage.
// Depends on q2e_pkg.
`default_nettype none
module q2e_root
	import q2e_pkg::*;
(
	input  wire                  clk,
	input  wire                  en,
	input  wire signed [TW-1:0]  t_in,
	output logic signed [TW-1:0] t_out,
	output logic signed [TW-1:0] c_out
);

	logic [NW-1:0]        n_s [0:SQ_ITERS];
	logic [NW-1:0]        r_s [0:SQ_ITERS];
	logic signed [TW-1:0] t_s [0:SQ_ITERS];
	logic [2*TW-1:0]      sq;

	// full-width square; operands sign-extend to the 64-bit context
	assign sq = t_in * t_in;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= (NW'(1) << (2 * (SQ_ITERS - 1))) - NW'(sq);
			r_s[0] <= '0;
			t_s[0] <= t_in;
		end
	end

	for (genvar i = 0; i < SQ_ITERS; i++) begin : g_iter
		logic [NW-1:0] bit_v, trial;
		assign bit_v = NW'(1) << (2 * (SQ_ITERS - 1 - i));
		assign trial = r_s[i] + bit_v;
		always_ff @(posedge clk) begin
			if (en) begin
				t_s[i+1] <= t_s[i];
				if (n_s[i] >= trial) begin
					n_s[i+1] <= n_s[i] - trial;
					r_s[i+1] <= (r_s[i] >> 1) + bit_v;
				end else begin
					n_s[i+1] <= n_s[i];
					r_s[i+1] <= r_s[i] >> 1;
				end
			end
		end
	end

	assign c_out = TW'(r_s[SQ_ITERS]);
	assign t_out = t_s[SQ_ITERS];

endmodule
`default_nettype wire

// ===== sv/q2e_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) as a 16-bit binary angle.
// Depends on q2e_pkg (arctangent table).
`default_nettype none
module q2e_cordic
	import q2e_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  wire                  clk,
	input  wire                  en,
	input  wire signed [CW-1:0]  y_in,
	input  wire signed [CW-1:0]  x_in,
	output logic [OW-1:0]        angle    // STEPS + 1 stages after the inputs
);

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic [AW-1:0]        z_s [0:STEPS];
	logic                 zero_s [0:STEPS];
	logic signed [CW-1:0] x_pre, y_pre;
	logic [AW-1:0]        z_pre;
	logic [AW-1:0]        z_rnd;

	// left half plane: rotate by +/- a quarter turn first
	always_comb begin
		x_pre = x_in;
		y_pre = y_in;
		z_pre = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = 32'h40000000;
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = 32'hC0000000;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x_pre;
			y_s[0]    <= y_pre;
			z_s[0]    <= z_pre;
			zero_s[0] <= (x_in == '0) && (y_in == '0);
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_ent(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_ent(i);
				end
			end
		end
	end

	assign z_rnd = z_s[STEPS] + 32'h00008000;
	assign angle = zero_s[STEPS] ? '0 : z_rnd[AW-1:AW-OW];

endmodule
`default_nettype wire

// ===== sv/quaternion_to_euler_angles.sv =====
// Top level: quaternion (Q2.14) in, ZYX roll/pitch/yaw binary angles out.
// Depends on q2e_pkg, q2e_front, q2e_root, q2e_cordic.
//
// Fully pipelined: one item is accepted every cycle unless the output stalls.
// The pitch path is the longest: three front stages of products and sums,
// 32 stages for the cosine square root (one result bit per stage), CORDIC_STEPS + 1
// arctangent stages and the output register; roll and yaw are delayed to match.
// A stall on the output freezes the whole pipeline; s_tready is high whenever
// the output register is empty or being taken. Angles: 32768 = pi.
`default_nettype none
module quaternion_to_euler_angles
	import q2e_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);

	localparam int CL       = CORDIC_STEPS + 1;
	localparam int ROOT_LAT = SQ_ITERS + 1;
	localparam int RD       = ROOT_LAT + 1;
	localparam int SD       = ROOT_LAT + CL;
	localparam int LAT      = ROOT_LAT + CL + 4;

	logic                 en;
	logic [LAT-1:0]       vld_s;
	atan_args_t           args;
	logic signed [TW-1:0] t_front, t_root, c_root;
	pitch_sat_t           sat_front;
	logic [OW-1:0]        roll_ang, yaw_ang, pitch_ang, pitch_fin;
	logic [OW-1:0]        roll_d_q [0:RD-1];
	logic [OW-1:0]        yaw_d_q  [0:RD-1];
	pitch_sat_t           sat_d_q  [0:SD-1];
	logic [47:0]          out_q;

	assign en       = m_tready || !vld_s[LAT-1];
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], s_tvalid};
		end
	end

	q2e_front u_front (
		.clk     (clk),
		.en      (en),
		.quat_x  (s_tdata[15:0]),
		.quat_y  (s_tdata[31:16]),
		.quat_z  (s_tdata[47:32]),
		.quat_w  (s_tdata[63:48]),
		.args    (args),
		.t_out   (t_front),
		.sat_out (sat_front)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk   (clk),
		.en    (en),
		.y_in  (CW'(args.sr)),
		.x_in  (CW'(args.cr)),
		.angle (roll_ang)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk   (clk),
		.en    (en),
		.y_in  (CW'(args.sy)),
		.x_in  (CW'(args.cy)),
		.angle (yaw_ang)
	);

	q2e_root u_root (
		.clk   (clk),
		.en    (en),
		.t_in  (t_front),
		.t_out (t_root),
		.c_out (c_root)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk   (clk),
		.en    (en),
		.y_in  (CW'(t_root)),
		.x_in  (CW'(c_root)),
		.angle (pitch_ang)
	);

	// roll/yaw wait for the square root; saturation flags ride alongside pitch
	always_ff @(posedge clk) begin
		if (en) begin
			roll_d_q[0] <= roll_ang;
			yaw_d_q[0]  <= yaw_ang;
			sat_d_q[0]  <= sat_front;
			for (int k = 1; k < RD; k++) begin
				roll_d_q[k] <= roll_d_q[k-1];
				yaw_d_q[k]  <= yaw_d_q[k-1];
			end
			for (int k = 1; k < SD; k++) begin
				sat_d_q[k] <= sat_d_q[k-1];
			end
		end
	end

	always_comb begin
		priority if (sat_d_q[SD-1].pos) begin
			pitch_fin = PITCH_POS;
		end else if (sat_d_q[SD-1].neg) begin
			pitch_fin = PITCH_NEG;
		end else begin
			pitch_fin = pitch_ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= {yaw_d_q[RD-1], pitch_fin, roll_d_q[RD-1]};
		end
	end

	assign m_tvalid = vld_s[LAT-1];
	assign m_tdata  = out_q;

endmodule
`default_nettype wire

// ===== sv/q2e_check.sv =====
// Port-level checks for quaternion_to_euler_angles, bound to the top level.
// No package dependencies.
`default_nettype none
module q2e_check (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [63:0] s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [47:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output drains");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind quaternion_to_euler_angles q2e_check u_q2e_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for quaternion_to_euler_angles: drives quaternion items on the
// input stream and checks the roll/pitch/yaw items against an integer CORDIC predictor.
// Depends on q2e_pkg and the block RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import q2e_pkg::*;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} euler_t;

	localparam int STEPS      = CORDIC_STEPS_DEF;
	localparam int LATENCY    = STEPS + 37;
	localparam int WDOG_LIMIT = 3000;
	localparam longint ONE_Q  = longint'(1) << (2 * QUAT_FRAC_BITS);

	localparam logic [31:0] ATAN_LUT [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // quat_x, quat_y, quat_z, quat_w
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // roll_angle, pitch_angle, yaw_angle

	euler_t angles_due[$];
	int     err_cnt;
	int     idle_cycles;
	int     sink_hold;      // cycles the receiver still holds off
	bit     hold_req;       // ask the receiver for one long hold-off
	bit     no_gaps;

	quaternion_to_euler_angles u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic logic [31:0] vec_angle(longint y, longint x);
		logic [31:0] z;
		longint      t, dx, dy;
		z = '0;
		if (x == 0 && y == 0)
			return 32'h0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 32'h40000000;
			end else begin
				x = -y; y = t; z = 32'hC0000000;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x = x + dy; y = y - dx; z = z + ATAN_LUT[i];
			end else begin
				x = x - dy; y = y + dx; z = z - ATAN_LUT[i];
			end
		end
		return z;
	endfunction

	function automatic logic [15:0] to_bam16(logic [31:0] z);
		logic [31:0] r;
		r = z + 32'h8000;
		return r[31:16];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic euler_t quat_to_euler(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		euler_t          e;
		longint          x, y, z, w, s, t, sr, cr, sy, cy;
		longint unsigned c;
		x = qx; y = qy; z = qz; w = qw;
		sr = 2 * (w * x + y * z);
		cr = ONE_Q - 2 * (x * x + y * y);
		sy = 2 * (w * z + x * y);
		cy = ONE_Q - 2 * (y * y + z * z);
		s  = 2 * (w * y - z * x);
		if (s >= ONE_Q)
			e.pitch = PITCH_POS;
		else if (s <= -ONE_Q)
			e.pitch = PITCH_NEG;
		else begin
			t = (TSH >= 0) ? (s <<< TSH) : (s >>> (-TSH));
			c = int_sqrt(longint'((longint'(1) << 30) - t) * longint'((longint'(1) << 30) + t));
			e.pitch = to_bam16(vec_angle(t, longint'(c)));
		end
		e.roll = to_bam16(vec_angle(sr, cr));
		e.yaw  = to_bam16(vec_angle(sy, cy));
		return e;
	endfunction

	// ---------------- driving ----------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
			logic signed [15:0] qz, logic signed [15:0] qw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tdata  = {qw, qz, qy, qx};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		angles_due.push_back(quat_to_euler(qx, qy, qz, qw));
	endtask

	// random unit quaternion, truncated to Q2.14
	task automatic send_unit_quat();
		real a, b, c, d, n;
		a = real'($urandom_range(0, 20000)) - 10000.0;
		b = real'($urandom_range(0, 20000)) - 10000.0;
		c = real'($urandom_range(0, 20000)) - 10000.0;
		d = real'($urandom_range(0, 20000)) - 10000.0;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0) begin
			a = 1.0; n = 1.0;
		end
		send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
			16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
	endtask

	function automatic logic signed [15:0] rand_comp();
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	always @(negedge clk) begin
		if (hold_req) begin
			m_tready <= 1'b0;
			sink_hold <= 300;
			hold_req = 1'b0;
		end else if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if (no_gaps)
			m_tready <= 1'b1;
		else begin
			automatic int r = $urandom_range(0, 99);
			if (r < 70)
				m_tready <= 1'b1;
			else if (r < 97)
				m_tready <= 1'b0;
			else begin
				m_tready <= 1'b0;
				sink_hold <= $urandom_range(10, 40);
			end
		end
	end

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $time);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (angles_due.size() == 0) begin
				report_mismatch("unexpected item", m_tdata[15:0], 16'h0);
			end else begin
				automatic euler_t e = angles_due.pop_front();
				if (m_tdata[15:0] !== e.roll)   report_mismatch("roll", m_tdata[15:0], e.roll);
				if (m_tdata[31:16] !== e.pitch) report_mismatch("pitch", m_tdata[31:16], e.pitch);
				if (m_tdata[47:32] !== e.yaw)   report_mismatch("yaw", m_tdata[47:32], e.yaw);
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- tests ----------------
	task automatic test_directed();
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);          // identity
		send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
		send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
		send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);          // roll half turn
		send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);          // yaw half turn
		send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
		send_quat(16'sd8192, 16'sd8192, 16'sd1000, -16'sd1000); // roll atan2(0,0)
		send_quat(16'sd8192, 16'sd8192, -16'sd5000, 16'sd5000);
		send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);      // pitch saturates high
		send_quat(16'sd0, -16'sd16384, 16'sd0, 16'sd16384);     // and low
		send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);      // just under one
		send_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
		send_quat(16'sd0, 16'sd11586, 16'sd0, 16'sd11586);
		send_quat(16'sd16384, 16'sd0, 16'sd16384, 16'sd0);      // negative s saturation
		send_quat(-16'sd16384, 16'sd0, 16'sd16384, 16'sd0);
		send_quat(16'sd100, -16'sd200, 16'sd300, -16'sd400);    // unnormalized
		send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
		send_quat(16'sd1, 16'sd1, 16'sd1, 16'sd1);
		send_quat(16'sd5793, 16'sd5793, 16'sd5793, 16'sd5793);
		send_quat(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000);  // full-scale components
		send_quat(16'sh8000, 16'sh0000, 16'sh0000, 16'sh7FFF);
	endtask

	task automatic test_unit_random(int n);
		repeat (n) send_unit_quat();
	endtask

	task automatic test_wild_random(int n);
		repeat (n) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
	endtask

	task automatic test_back_to_back(int n);
		no_gaps = 1'b1;
		repeat (n) send_unit_quat();
		no_gaps = 1'b0;
	endtask

	// receiver holds off long enough for the pipeline to fill and stall the input
	task automatic test_sink_stall(int n);
		hold_req = 1'b1;
		no_gaps = 1'b1;
		repeat (n) send_unit_quat();
		no_gaps = 1'b0;
	endtask

	initial begin
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		sink_hold   = 0;
		hold_req    = 1'b0;
		no_gaps     = 1'b0;
		err_cnt     = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_unit_random(450);
		test_back_to_back(100);
		test_sink_stall(120);
		test_wild_random(150);
		@(negedge clk);
		s_tvalid = 1'b0;

		while (angles_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/q2e_pkg.sv
sv/q2e_front.sv
sv/q2e_root.sv
sv/q2e_cordic.sv
sv/quaternion_to_euler_angles.sv
sv/q2e_check.sv
dv/tb_top.sv
